[sv/kwm_pkg.sv]
// ----------------------------------------------------------------------------
// kwm_pkg
// Types, constants and codes shared by the newest-first merge block.
// ----------------------------------------------------------------------------
package kwm_pkg;

    localparam int LISTS_DEFAULT = 8;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_HEAD  = 2'd1;
    localparam logic [1:0] OP_END   = 2'd2;

    localparam logic [1:0] KIND_ROW    = 2'd0;
    localparam logic [1:0] KIND_REFILL = 2'd1;
    localparam logic [1:0] KIND_DONE   = 2'd2;

    localparam logic [1:0] CFG_LIST_COUNT = 2'd0;
    localparam logic [1:0] CFG_PAGE_LIMIT = 2'd1;
    localparam logic [1:0] CFG_SKIP_COUNT = 2'd2;

    typedef enum logic [1:0] {
        ST_ENDED   = 2'd0,
        ST_PENDING = 2'd1,
        ST_VALID   = 2'd2
    } slot_status_t;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_SCAN,
        FSM_DECIDE,
        FSM_OUT1,
        FSM_OUT2
    } fsm_state_t;

    typedef struct packed {
        logic [1:0]         op;
        logic [2:0]         list_index;
        logic [63:0]        issued_time;
        logic [7:0]         severity;
        logic [7:0]         field_code;
        logic [7:0]         edge_code;
        logic signed [31:0] reading;
        logic               is_resolved;
        logic [63:0]        resolved_time;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [2:0]         source_list;
        logic [63:0]        out_issued_time;
        logic [7:0]         out_severity;
        logic [7:0]         out_field_code;
        logic [7:0]         out_edge_code;
        logic signed [31:0] out_reading;
        logic               out_resolved;
        logic [63:0]        out_resolved_time;
        logic               last;
    } out_item_t;

    // Row payload held in each cell.
    typedef struct packed {
        logic [63:0]        issued_time;
        logic [7:0]         severity;
        logic [7:0]         field_code;
        logic [7:0]         edge_code;
        logic signed [31:0] reading;
        logic               is_resolved;
        logic [63:0]        resolved_time;
    } row_t;

    // Candidate travelling along the chain during a scan.
    typedef struct packed {
        logic        found;
        logic [63:0] best_time;
        logic [5:0]  best_index;
        row_t        row;
    } cand_t;

endpackage

[sv/kway_newest_first_merge.sv]
// ----------------------------------------------------------------------------
// kway_newest_first_merge
// Merges up to LISTS newest-first lists into one newest-first page.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Payload     Handshake
//   in        input      in_item_t   in_valid / in_stall
//   out       output     out_item_t  out_valid / out_stall
//   cfg       input      index,data  cfg_we
//
// A head row or end mark for the last pending list starts a selection: the
// candidate register walks the chain of cells, one cell per cycle, then one
// or two results follow. Items that leave a list pending go from the decide
// state straight back to idle. The input is stalled while a request is being
// worked on or its results wait at the output. Reset clears all slot status
// to ended and drops any active query; head rows are not cleared, as a slot
// is read only once it holds a valid head.
// ----------------------------------------------------------------------------
module kway_newest_first_merge
    import kwm_pkg::*;
#(
    parameter int LISTS = LISTS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output out_item_t   out_data,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [24:0] cfg_data
);

    localparam int IDX_W = (LISTS > 1) ? $clog2(LISTS) : 1;
    localparam int CNT_W = $clog2(LISTS + 1);

    // Configuration registers.
    logic [3:0]  list_count_reg;
    logic [6:0]  page_limit_reg;
    logic [24:0] skip_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            list_count_reg <= 4'd1;
            page_limit_reg <= 7'd4;
            skip_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LIST_COUNT: list_count_reg <= cfg_data[3:0];
                CFG_PAGE_LIMIT: page_limit_reg <= cfg_data[6:0];
                CFG_SKIP_COUNT: skip_count_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Query state.
    fsm_state_t  state_reg, state_next;
    logic [24:0] skip_left_reg, skip_left_next;
    logic [6:0]  emitted_reg, emitted_next;
    logic        active_reg, active_next;
    logic [CNT_W-1:0] scan_reg, scan_next;
    cand_t       cand_reg, cand_next;
    out_item_t   res1_reg, res1_next, res2_reg, res2_next;
    logic        two_reg, two_next;

    // Cell chain. Every cell sees the candidate register; only the cell whose
    // turn it is may replace it.
    slot_status_t status    [LISTS];
    cand_t        cand_link [LISTS];
    logic [LISTS-1:0] load_en, set_en, scan_en;
    slot_status_t set_status [LISTS];
    row_t         load_row;
    logic         any_pending;

    assign load_row = '{issued_time: in_data.issued_time, severity: in_data.severity,
                        field_code: in_data.field_code, edge_code: in_data.edge_code,
                        reading: in_data.reading, is_resolved: in_data.is_resolved,
                        resolved_time: in_data.is_resolved ? in_data.resolved_time : 64'd0};

    genvar g;
    generate
        for (g = 0; g < LISTS; g++)
        begin : g_cell
            kwm_cell #(.IDX_W(IDX_W)) u_cell
            (
                .clk        (clk),
                .rst_n      (rst_n),
                .my_index   (IDX_W'(g)),
                .load_en    (load_en[g]),
                .load_row   (load_row),
                .set_en     (set_en[g]),
                .set_status (set_status[g]),
                .scan_en    (scan_en[g]),
                .cand_in    (cand_reg),
                .cand_out   (cand_link[g]),
                .status     (status[g])
            );
        end
    endgenerate

    always_comb
    begin
        any_pending = 1'b0;
        for (int i = 0; i < LISTS; i++)
        begin
            if (status[i] == ST_PENDING)
            begin
                any_pending = 1'b1;
            end
        end
    end

    logic in_acc;
    logic out_acc;
    logic idx_ok;
    logic [3:0] n_lists;

    assign in_stall = (state_reg != FSM_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign out_acc  = out_valid && !out_stall;
    assign idx_ok   = (32'(in_data.list_index) < LISTS);
    assign n_lists  = (32'(list_count_reg) > LISTS) ? 4'(LISTS) : list_count_reg;

    // Pick up the candidate from the current cell during a scan.
    logic [IDX_W-1:0] scan_idx;
    assign scan_idx = scan_reg[IDX_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        skip_left_next = skip_left_reg;
        emitted_next   = emitted_reg;
        active_next    = active_reg;
        scan_next      = scan_reg;
        cand_next      = cand_reg;
        res1_next      = res1_reg;
        res2_next      = res2_reg;
        two_next       = two_reg;
        load_en        = '0;
        set_en         = '0;
        scan_en        = '0;
        for (int i = 0; i < LISTS; i++)
        begin
            set_status[i] = ST_PENDING;
        end
        out_valid = 1'b0;
        out_data  = res1_reg;

        unique case (state_reg)
            FSM_IDLE:
            begin
                if (in_acc)
                begin
                    if (in_data.op == OP_START)
                    begin
                        for (int i = 0; i < LISTS; i++)
                        begin
                            set_en[i]     = 1'b1;
                            set_status[i] = (i < 32'(n_lists)) ? ST_PENDING : ST_ENDED;
                        end
                        skip_left_next = skip_count_reg;
                        emitted_next   = '0;
                        active_next    = 1'b1;
                        state_next     = FSM_DECIDE;
                        scan_next      = '0;
                        cand_next      = '0;
                    end
                    else if ((in_data.op == OP_HEAD || in_data.op == OP_END) && active_reg
                             && idx_ok && status[in_data.list_index[IDX_W-1:0]] == ST_PENDING)
                    begin
                        set_en[in_data.list_index[IDX_W-1:0]] = 1'b1;
                        if (in_data.op == OP_HEAD)
                        begin
                            load_en[in_data.list_index[IDX_W-1:0]]    = 1'b1;
                            set_status[in_data.list_index[IDX_W-1:0]] = ST_VALID;
                        end
                        else
                        begin
                            set_status[in_data.list_index[IDX_W-1:0]] = ST_ENDED;
                        end
                        state_next = FSM_DECIDE;
                        scan_next  = '0;
                        cand_next  = '0;
                    end
                end
            end

            FSM_DECIDE:
            begin
                // Status now settled; either nothing to do, finish, or scan.
                if (any_pending)
                begin
                    state_next = FSM_IDLE;
                end
                else if (emitted_reg >= page_limit_reg)
                begin
                    active_next = 1'b0;
                    res1_next   = '0;
                    res1_next.kind = KIND_DONE;
                    res1_next.last = 1'b1;
                    two_next    = 1'b0;
                    state_next  = FSM_OUT1;
                end
                else
                begin
                    state_next = FSM_SCAN;
                end
            end

            FSM_SCAN:
            begin
                scan_en[scan_idx] = 1'b1;
                cand_next = cand_link[scan_idx];
                if (32'(scan_reg) == LISTS - 1)
                begin
                    res1_next = '0;
                    res2_next = '0;
                    if (!cand_next.found)
                    begin
                        active_next    = 1'b0;
                        res1_next.kind = KIND_DONE;
                        res1_next.last = 1'b1;
                        two_next       = 1'b0;
                    end
                    else if (skip_left_reg != '0)
                    begin
                        skip_left_next = skip_left_reg - 25'd1;
                        set_en[cand_next.best_index[IDX_W-1:0]]     = 1'b1;
                        set_status[cand_next.best_index[IDX_W-1:0]] = ST_PENDING;
                        res1_next.kind        = KIND_REFILL;
                        res1_next.source_list = cand_next.best_index[2:0];
                        res1_next.last        = 1'b1;
                        two_next              = 1'b0;
                    end
                    else
                    begin
                        set_en[cand_next.best_index[IDX_W-1:0]]     = 1'b1;
                        set_status[cand_next.best_index[IDX_W-1:0]] = ST_PENDING;
                        emitted_next = emitted_reg + 7'd1;
                        res1_next.kind              = KIND_ROW;
                        res1_next.source_list       = cand_next.best_index[2:0];
                        res1_next.out_issued_time   = cand_next.row.issued_time;
                        res1_next.out_severity      = cand_next.row.severity;
                        res1_next.out_field_code    = cand_next.row.field_code;
                        res1_next.out_edge_code     = cand_next.row.edge_code;
                        res1_next.out_reading       = cand_next.row.reading;
                        res1_next.out_resolved      = cand_next.row.is_resolved;
                        res1_next.out_resolved_time = cand_next.row.resolved_time;
                        two_next = 1'b1;
                        res2_next.last = 1'b1;
                        if (emitted_next >= page_limit_reg)
                        begin
                            active_next    = 1'b0;
                            res2_next.kind = KIND_DONE;
                        end
                        else
                        begin
                            res2_next.kind        = KIND_REFILL;
                            res2_next.source_list = cand_next.best_index[2:0];
                        end
                    end
                    state_next = FSM_OUT1;
                end
                else
                begin
                    scan_next = scan_reg + CNT_W'(1);
                end
            end

            FSM_OUT1:
            begin
                out_valid = 1'b1;
                out_data  = res1_reg;
                if (out_acc)
                begin
                    state_next = two_reg ? FSM_OUT2 : FSM_IDLE;
                end
            end

            FSM_OUT2:
            begin
                out_valid = 1'b1;
                out_data  = res2_reg;
                if (out_acc)
                begin
                    state_next = FSM_IDLE;
                end
            end

            default: state_next = FSM_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FSM_IDLE;
            skip_left_reg <= '0;
            emitted_reg   <= '0;
            active_reg    <= 1'b0;
            scan_reg      <= '0;
            two_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            skip_left_reg <= skip_left_next;
            emitted_reg   <= emitted_next;
            active_reg    <= active_next;
            scan_reg      <= scan_next;
            two_reg       <= two_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cand_reg <= cand_next;
        res1_reg <= res1_next;
        res2_reg <= res2_next;
    end

endmodule

[sv/kwm_cell.sv]
// ----------------------------------------------------------------------------
// kwm_cell
// One list slot: holds its head row and status, and on its turn in a scan
// offers its head to the candidate register if it beats the best so far.
// ----------------------------------------------------------------------------
module kwm_cell
    import kwm_pkg::*;
#(
    parameter int IDX_W = 3
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [IDX_W-1:0]   my_index,
    input  logic               load_en,
    input  row_t               load_row,
    input  logic               set_en,
    input  slot_status_t       set_status,
    input  logic               scan_en,
    input  cand_t              cand_in,
    output cand_t              cand_out,
    output slot_status_t       status
);

    row_t         row_reg;
    slot_status_t status_reg;
    slot_status_t status_next;

    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            row_reg <= load_row;
        end
    end

    always_comb
    begin
        status_next = status_reg;
        if (set_en)
        begin
            status_next = set_status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg <= ST_ENDED;
        end
        else
        begin
            status_reg <= status_next;
        end
    end

    // A strictly greater time wins, so on a tie the earlier (lower) slot stays.
    always_comb
    begin
        cand_out = cand_in;
        if (scan_en && status_reg == ST_VALID && row_reg.issued_time > cand_in.best_time)
        begin
            cand_out.found      = 1'b1;
            cand_out.best_time  = row_reg.issued_time;
            cand_out.best_index = 6'(my_index);
            cand_out.row        = row_reg;
        end
    end

    assign status = status_reg;

endmodule
